// ===== rtl/mmn_pkg.sv =====
// Shared constants, types and command/status structs for the min-max normaliser.
`default_nettype none

package mmn_pkg;

  localparam int SET_DEPTH   = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_BITS   = $clog2(SET_DEPTH);
  localparam int COUNT_BITS  = $clog2(SET_DEPTH + 1);
  localparam int FRAC_BITS   = 15;
  localparam int QUOT_BITS   = FRAC_BITS + 1;
  localparam int STEP_BITS   = $clog2(QUOT_BITS);

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_FETCH,
    ST_LOAD,
    ST_DIVIDE,
    ST_HANDOFF
  } state_t;

  typedef struct packed {
    logic take;
    logic rd_en;
    logic div_load;
    logic div_step;
    logic div_first;
    logic out_load;
    logic set_clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic flat;
    logic last_elem;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/min_max_normalizer_core.sv =====
// Min-max normaliser top level: sample collection and normalised result output.
// Samples are accepted one per cycle and written into a 64-entry store while the
// running minimum and maximum are tracked; samples beyond 64 in a set are dropped.
// A request marked last_sample starts output: each stored sample is read back and
// divided by a 16-step restoring divider, giving (sample - min) * 32768 / (max - min)
// truncated; each result passes through read, load, the 16 divide steps and hand-off.
// When all samples are equal every result is 0 with flat_error set and the divide
// steps are skipped. No samples are taken while a set is being output; the output
// register lets the next division proceed while a result waits for result_ready.
`default_nettype none

module min_max_normalizer_core
  import mmn_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sample_valid,
  output logic                               sample_ready,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  input  wire logic                          last_sample,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic             [QUOT_BITS-1:0]   scaled_value,
  output logic                               flat_error,
  output logic                               last_result
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mmn_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .last_sample  (last_sample),
    .sample_ready (sample_ready),
    .status       (status),
    .cmd          (cmd)
  );

  mmn_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample       (sample),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .scaled_value (scaled_value),
    .flat_error   (flat_error),
    .last_result  (last_result)
  );

endmodule

`default_nettype wire

// ===== rtl/mmn_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none

module mmn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mmn_ctrl.sv =====
// Sequencing state machine: collect, then fetch/divide/hand off each stored sample.
`default_nettype none

module mmn_ctrl
  import mmn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       sample_valid,
  input  wire logic       last_sample,
  output logic            sample_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t               state;
  state_t               state_next;
  logic [STEP_BITS-1:0] step;
  logic [STEP_BITS-1:0] step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_COLLECT: begin
        if (sample_valid && last_sample) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        step_next  = '0;
        state_next = status.flat ? ST_HANDOFF : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        step_next = step + 1'b1;
        if (step == STEP_BITS'(QUOT_BITS - 1)) begin
          state_next = ST_HANDOFF;
        end
      end
      ST_HANDOFF: begin
        if (status.out_free) begin
          state_next = status.last_elem ? ST_COLLECT : ST_FETCH;
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  always_comb begin
    cmd          = '0;
    sample_ready = 1'b0;
    case (state)
      ST_COLLECT: begin
        sample_ready = 1'b1;
        cmd.take     = sample_valid;
      end
      ST_FETCH: begin
        cmd.rd_en = 1'b1;
      end
      ST_LOAD: begin
        cmd.div_load = 1'b1;
      end
      ST_DIVIDE: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (step == '0);
      end
      ST_HANDOFF: begin
        if (status.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.set_clear = status.last_elem;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mmn_datapath.sv =====
// Sample store, running min/max, restoring divider and output register.
`default_nettype none

module mmn_datapath
  import mmn_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ctrl_cmd_t                     cmd,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output dp_status_t                         status,
  output logic                               result_valid,
  input  wire logic                          result_ready,
  output logic             [QUOT_BITS-1:0]   scaled_value,
  output logic                               flat_error,
  output logic                               last_result
);

  logic        [COUNT_BITS-1:0]  fill_count;
  logic signed [SAMPLE_BITS-1:0] run_min;
  logic signed [SAMPLE_BITS-1:0] run_max;
  logic        [ADDR_BITS-1:0]   idx;
  logic        [SAMPLE_BITS-1:0] rd_data;
  logic        [SAMPLE_BITS:0]   rem;
  logic        [SAMPLE_BITS-1:0] span;
  logic        [QUOT_BITS-1:0]   quot;

  logic                   store_en;
  logic                   flat;
  logic                   last_elem;
  logic [SAMPLE_BITS-1:0] span_c;
  logic [SAMPLE_BITS-1:0] diff_c;
  logic [SAMPLE_BITS:0]   trial;
  logic                   ge;

  assign store_en  = cmd.take && (fill_count < COUNT_BITS'(SET_DEPTH));
  assign flat      = (run_max <= run_min);
  assign span_c    = run_max - run_min;
  assign diff_c    = rd_data - run_min;
  assign last_elem = ((COUNT_BITS'(idx) + 1'b1) == fill_count);
  assign trial     = cmd.div_first ? rem : {rem[SAMPLE_BITS-1:0], 1'b0};
  assign ge        = (trial >= {1'b0, span});

  assign status.flat      = flat;
  assign status.last_elem = last_elem;
  assign status.out_free  = !result_valid || result_ready;

  mmn_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (SET_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (fill_count[ADDR_BITS-1:0]),
    .wr_data (sample),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      run_min      <= SMP_MAX;
      run_max      <= SMP_MIN;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.set_clear) begin
        fill_count <= '0;
        run_min    <= SMP_MAX;
        run_max    <= SMP_MIN;
        idx        <= '0;
      end else begin
        if (store_en) begin
          fill_count <= fill_count + 1'b1;
          if (sample < run_min) begin
            run_min <= sample;
          end
          if (sample > run_max) begin
            run_max <= sample;
          end
        end
        if (cmd.out_load) begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // restoring division, quotient MSB first; first step has no shift
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem  <= {1'b0, diff_c};
      span <= span_c;
      quot <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? (trial - {1'b0, span}) : trial;
      quot <= {quot[QUOT_BITS-2:0], ge};
    end
    if (cmd.out_load) begin
      scaled_value <= flat ? '0 : quot;
      flat_error   <= flat;
      last_result  <= last_elem;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mmn_checker.sv =====
// Port-level assertions for the min-max normaliser, bound to the top level.
`default_nettype none

module mmn_checker
  import mmn_pkg::*;
(
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          sample_valid,
  input wire logic                          sample_ready,
  input wire logic                          last_sample,
  input wire logic                          result_valid,
  input wire logic                          result_ready,
  input wire logic        [QUOT_BITS-1:0]   scaled_value,
  input wire logic                          flat_error,
  input wire logic                          last_result
);

  localparam logic [QUOT_BITS-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(scaled_value)
      && $stable(flat_error) && $stable(last_result))
    else $error("stalled result request changed");

  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && flat_error |-> scaled_value == '0)
    else $error("flat set gave non-zero value");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> scaled_value <= ONE_Q)
    else $error("normalised value above 1.0");

  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready && last_sample |=> !sample_ready)
    else $error("samples taken while set is being output");

  a_reset: assert property (@(posedge clk)
    rst |=> sample_ready && !result_valid)
    else $error("bad state after reset");

endmodule

bind min_max_normalizer_core mmn_checker u_mmn_checker (.*);

`default_nettype wire

// ===== tb/tb_min_max_normalizer_core.sv =====
// Self-checking testbench for the min-max normaliser core: directed and random sample sets.
`timescale 1ns / 100ps

module tb_min_max_normalizer_core;
  import mmn_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 64;

  typedef struct packed {
    logic [QUOT_BITS-1:0] value;
    logic                 flat;
    logic                 last;
  } norm_result_t;

  typedef enum {FILL_FULL, FILL_NARROW, FILL_EXTREME, FILL_FLAT} fill_mode_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          sample_valid = 1'b0;
  logic                          sample_ready;
  logic signed [SAMPLE_BITS-1:0] sample = '0;
  logic                          last_sample = 1'b0;
  logic                          result_valid;
  logic                          result_ready = 1'b0;
  logic        [QUOT_BITS-1:0]   scaled_value;
  logic                          flat_error;
  logic                          last_result;

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int idle_cycles     = 0;
  int error_count     = 0;
  int results_checked = 0;
  int samples_sent    = 0;
  int sets_sent       = 0;
  int flat_sets       = 0;
  int overfull_sets   = 0;

  // predictor state
  logic signed [SAMPLE_BITS-1:0] stored_samples [SET_DEPTH];
  logic signed [SAMPLE_BITS-1:0] set_min = SMP_MAX;
  logic signed [SAMPLE_BITS-1:0] set_max = SMP_MIN;
  int                            set_fill = 0;
  logic                          set_overflowed = 1'b0;
  norm_result_t                  expected_results [$];

  min_max_normalizer_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .last_sample  (last_sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .scaled_value (scaled_value),
    .flat_error   (flat_error),
    .last_result  (last_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Store one accepted request; on last, queue the normalised set.
  task automatic absorb_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic l);
    longint       span;
    longint       offset;
    logic         flat;
    norm_result_t r;
    if (set_fill < SET_DEPTH) begin
      stored_samples[set_fill] = s;
      set_fill++;
      if (s < set_min) set_min = s;
      if (s > set_max) set_max = s;
    end else begin
      set_overflowed = 1'b1;
    end
    if (l) begin
      flat = (set_max <= set_min);
      span = longint'(set_max) - longint'(set_min);
      for (int i = 0; i < set_fill; i++) begin
        r.flat = flat;
        r.last = (i == set_fill - 1);
        if (flat) begin
          r.value = '0;
        end else begin
          offset  = longint'(stored_samples[i]) - longint'(set_min);
          r.value = QUOT_BITS'((offset << FRAC_BITS) / span);
        end
        expected_results.push_back(r);
      end
      sets_sent++;
      if (flat) flat_sets++;
      if (set_overflowed) overfull_sets++;
      set_min        = SMP_MAX;
      set_max        = SMP_MIN;
      set_fill       = 0;
      set_overflowed = 1'b0;
    end
  endtask

  // Called just after a falling edge; returns just after a falling edge.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      sample       <= SAMPLE_BITS'($urandom);
      last_sample  <= 1'($urandom_range(1));
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    last_sample  <= l;
    @(posedge clk);
    while (!(sample_valid && sample_ready)) @(posedge clk);
    samples_sent++;
    absorb_sample(s, l);
    @(negedge clk);
  endtask

  task automatic send_set(input int len, input fill_mode_t mode);
    logic signed [SAMPLE_BITS-1:0] base;
    logic signed [SAMPLE_BITS-1:0] s;
    base = SAMPLE_BITS'($urandom);
    for (int i = 0; i < len; i++) begin
      case (mode)
        FILL_FULL:    s = SAMPLE_BITS'($urandom);
        FILL_NARROW:  s = base + SAMPLE_BITS'($urandom_range(3));
        FILL_EXTREME: begin
          case ($urandom_range(3))
            0:       s = SMP_MIN;
            1:       s = SMP_MAX;
            2:       s = '0;
            default: s = '1;
          endcase
        end
        default:      s = base;
      endcase
      send_sample(s, i == len - 1);
    end
  endtask

  task automatic test_extremes();
    send_sample(SMP_MIN, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
  endtask

  // single-sample sets and a set of equal values
  task automatic test_flat_sets();
    send_sample(16'sd1234, 1'b1);
    send_sample(SMP_MAX, 1'b1);
    send_sample(SMP_MIN, 1'b1);
    send_sample(-16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b1);
  endtask

  task automatic test_small_spans();
    send_sample(16'sd100, 1'b0);
    send_sample(16'sd101, 1'b1);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(16'sd10, 1'b1);
    send_sample(16'sd32766, 1'b0);
    send_sample(SMP_MAX, 1'b0);
    send_sample(16'sd32765, 1'b1);
  endtask

  // extra requests past a full store are dropped, the last one still ends the set
  task automatic test_store_overflow();
    send_set(SET_DEPTH + 3, FILL_FULL);
  endtask

  task automatic test_random_sets(input int budget);
    int start;
    int pick;
    int len;
    fill_mode_t mode;
    start = samples_sent;
    while (samples_sent - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 6) len = $urandom_range(SET_DEPTH + 4, SET_DEPTH - 4);
      else if (pick < 20) len = 1;
      else len = $urandom_range(12, 2);
      pick = $urandom_range(9);
      if (pick < 5) mode = FILL_FULL;
      else if (pick < 7) mode = FILL_NARROW;
      else if (pick < 9) mode = FILL_EXTREME;
      else mode = FILL_FLAT;
      send_set(len, mode);
    end
  endtask

  function automatic void compare_field(input string name, input logic [QUOT_BITS-1:0] want,
                                        input logic [QUOT_BITS-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic check_result();
    norm_result_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      $display("%0t: unexpected result, expected none, got value %0d flat %b last %b",
               $time, scaled_value, flat_error, last_result);
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      compare_field("scaled_value", want.value, scaled_value);
      compare_field("flat_error", QUOT_BITS'(want.flat), QUOT_BITS'(flat_error));
      compare_field("last_result", QUOT_BITS'(want.last), QUOT_BITS'(last_result));
    end
  endtask

  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) check_result();
  end

  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 24;
    recv_idle_pct = 66;
    test_extremes();
    test_flat_sets();
    test_small_spans();
    test_store_overflow();
    test_random_sets(75);

    send_idle_pct = 66;
    recv_idle_pct = 24;
    test_random_sets(75);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sets(75);

    sample_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d samples in %0d sets (%0d flat, %0d over-full); checked %0d results.",
             samples_sent, sets_sent, flat_sets, overfull_sets, results_checked);
    $display("Mismatches: %0d", error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
